// ===== hdl/ufpc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ufpc_pkg: shared definitions for the union-find engine
// Table size, index widths and the command/status bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package ufpc_pkg;

  localparam int NODES  = 1024;
  localparam int NODE_W = 10;
  localparam int IDX_W  = (NODES > 1) ? $clog2(NODES) : 1;

  typedef struct packed {
    logic load;        // capture input transaction
    logic start_u;     // begin a find at u_node
    logic start_v;     // begin a find at v_node
    logic step_cur;    // follow the parent link just read
    logic rd_walk;     // read at the compression pointer instead of cur
    logic wr_walk;     // point walk node at root, advance walk
    logic save_ru;     // keep root of u
    logic wr_link;     // link root of v under root of u
    logic note_merge;  // record whether the roots differed
    logic clr_start;   // restart the clearing sweep
    logic clr_wr;      // write one self link
    logic out_load;    // load the result register
    logic out_zero;    // result is all zeros
  } dp_cmd_t;

  typedef struct packed {
    logic is_clear;
    logic out_of_range;
    logic cur_is_root;
    logic walk_at_root;
    logic roots_differ;
    logic clr_last;
    logic out_free;
  } dp_status_t;

endpackage
`default_nettype wire

// ===== hdl/ufpc_dpath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ufpc_dpath: parent table and walk registers
// Holds the parent-link memory, the find and compression pointers,
// the clearing counter and the result register.
// ----------------------------------------------------------------------------
module ufpc_dpath (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire ufpc_pkg::dp_cmd_t       cmd,
  output ufpc_pkg::dp_status_t         status,
  input  wire logic                    in_action,
  input  wire logic [ufpc_pkg::NODE_W-1:0] in_u_node,
  input  wire logic [ufpc_pkg::NODE_W-1:0] in_v_node,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic                         out_merged,
  output logic [ufpc_pkg::NODE_W-1:0]  out_root
);
  import ufpc_pkg::*;

  logic [IDX_W-1:0]  mem [NODES];
  logic [IDX_W-1:0]  rd_data_r;
  logic [IDX_W-1:0]  rd_addr;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [IDX_W-1:0]  wr_data;

  logic              act_r;
  logic [NODE_W-1:0] u_r;
  logic [NODE_W-1:0] v_r;
  logic [IDX_W-1:0]  cur_r;
  logic [IDX_W-1:0]  walk_r;
  logic [IDX_W-1:0]  ru_r;
  logic              merged_r;
  logic [IDX_W-1:0]  clr_cnt_r;
  logic [IDX_W-1:0]  clr_cnt_nxt;
  logic              out_valid_r;
  logic              out_merged_r;
  logic [NODE_W-1:0] out_root_r;

  always_comb begin
    rd_addr = cmd.rd_walk ? walk_r : cur_r;
    wr_en   = cmd.wr_walk | cmd.wr_link | cmd.clr_wr;
    wr_addr = cur_r;
    wr_data = ru_r;
    if (cmd.clr_wr) begin
      wr_addr = clr_cnt_r;
      wr_data = clr_cnt_r;
    end else if (cmd.wr_walk) begin
      wr_addr = walk_r;
      wr_data = cur_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r <= in_action;
      u_r   <= in_u_node;
      v_r   <= in_v_node;
    end
    if (cmd.start_u) begin
      cur_r  <= IDX_W'(u_r);
      walk_r <= IDX_W'(u_r);
    end else if (cmd.start_v) begin
      cur_r  <= IDX_W'(v_r);
      walk_r <= IDX_W'(v_r);
    end else begin
      if (cmd.step_cur) cur_r <= rd_data_r;
      if (cmd.wr_walk)  walk_r <= rd_data_r;
    end
    if (cmd.save_ru)    ru_r <= cur_r;
    if (cmd.note_merge) merged_r <= (ru_r != cur_r);
    if (cmd.out_load) begin
      out_merged_r <= cmd.out_zero ? 1'b0 : merged_r;
      out_root_r   <= cmd.out_zero ? '0 : NODE_W'(ru_r);
    end
  end

  always_comb begin
    clr_cnt_nxt = clr_cnt_r;
    if (cmd.clr_start) begin
      clr_cnt_nxt = '0;
    end else if (cmd.clr_wr) begin
      clr_cnt_nxt = status.clr_last ? '0 : clr_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      clr_cnt_r <= clr_cnt_nxt;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    status.is_clear     = act_r;
    status.out_of_range = (32'(u_r) >= 32'(NODES)) || (32'(v_r) >= 32'(NODES));
    status.cur_is_root  = (rd_data_r == cur_r);
    status.walk_at_root = (walk_r == cur_r);
    status.roots_differ = (ru_r != cur_r);
    status.clr_last     = (clr_cnt_r == IDX_W'(NODES - 1));
    status.out_free     = !out_valid_r || !out_stall;
  end

  assign out_valid  = out_valid_r;
  assign out_merged = out_merged_r;
  assign out_root   = out_root_r;

endmodule
`default_nettype wire

// ===== hdl/ufpc_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ufpc_ctrl: sequencer for the union-find engine
// Steps through decode, two finds with path compression, the link,
// the clearing sweep and the result handoff.
// ----------------------------------------------------------------------------
module ufpc_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire ufpc_pkg::dp_status_t status,
  output ufpc_pkg::dp_cmd_t         cmd
);
  import ufpc_pkg::*;

  typedef enum logic [9:0] {
    S_INIT   = 10'b00_0000_0001,
    S_IDLE   = 10'b00_0000_0010,
    S_DECODE = 10'b00_0000_0100,
    S_CLR    = 10'b00_0000_1000,
    S_FRD    = 10'b00_0001_0000,
    S_FCHK   = 10'b00_0010_0000,
    S_CCHK   = 10'b00_0100_0000,
    S_CWR    = 10'b00_1000_0000,
    S_LINK   = 10'b01_0000_0000,
    S_OUT    = 10'b10_0000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   phase_r, phase_nxt;   // 0: finding root of u, 1: root of v
  logic   zero_r, zero_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    phase_nxt = phase_r;
    zero_nxt  = zero_r;
    unique case (state_r)
      S_INIT: begin
        cmd.clr_wr = 1'b1;
        if (status.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (status.is_clear) begin
          cmd.clr_start = 1'b1;
          zero_nxt      = 1'b1;
          state_nxt     = S_CLR;
        end else if (status.out_of_range) begin
          zero_nxt  = 1'b1;
          state_nxt = S_OUT;
        end else begin
          cmd.start_u = 1'b1;
          zero_nxt    = 1'b0;
          phase_nxt   = 1'b0;
          state_nxt   = S_FRD;
        end
      end
      S_CLR: begin
        cmd.clr_wr = 1'b1;
        if (status.clr_last) state_nxt = S_OUT;
      end
      S_FRD: begin
        state_nxt = S_FCHK;
      end
      S_FCHK: begin
        if (status.cur_is_root) begin
          state_nxt = S_CCHK;
        end else begin
          cmd.step_cur = 1'b1;
          state_nxt    = S_FRD;
        end
      end
      S_CCHK: begin
        if (status.walk_at_root) begin
          if (!phase_r) begin
            cmd.save_ru = 1'b1;
            cmd.start_v = 1'b1;
            phase_nxt   = 1'b1;
            state_nxt   = S_FRD;
          end else begin
            state_nxt = S_LINK;
          end
        end else begin
          cmd.rd_walk = 1'b1;
          state_nxt   = S_CWR;
        end
      end
      S_CWR: begin
        cmd.wr_walk = 1'b1;
        state_nxt   = S_CCHK;
      end
      S_LINK: begin
        // cur holds the root of v here
        cmd.note_merge = 1'b1;
        state_nxt      = S_OUT;
      end
      S_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_zero = zero_r;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      phase_r <= 1'b0;
      zero_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      zero_r  <= zero_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule
`default_nettype wire

// ===== hdl/ufpc_link.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ufpc_link: link decision
// Gates the root link write on the two roots being different and
// merges it into the controller's command bundle.
// ----------------------------------------------------------------------------
module ufpc_link (
  input  wire ufpc_pkg::dp_cmd_t    cmd_in,
  input  wire logic                 link_state,
  input  wire logic                 roots_differ,
  output ufpc_pkg::dp_cmd_t         cmd_out
);
  import ufpc_pkg::*;

  always_comb begin
    cmd_out         = cmd_in;
    cmd_out.wr_link = link_state & roots_differ;
  end

endmodule
`default_nettype wire

// ===== hdl/union_find_path_compression.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// union_find_path_compression: disjoint-set union engine
// Union and clear transactions over a 1024-entry parent-link table.
// ----------------------------------------------------------------------------
// One transaction at a time. A union walks from u_node and from v_node to their
// roots; path compression takes a read and then a write in the parent table
// for every node on a path. A clear rewrites the table one entry a cycle.
// After reset the same clearing pass runs with in_stall high. Out-of-range
// requests return zeros. A finished result waits in an output register and
// does not block the next transaction from entering.
// ----------------------------------------------------------------------------
module union_find_path_compression (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        in_action,
  input  wire logic [ufpc_pkg::NODE_W-1:0] in_u_node,
  input  wire logic [ufpc_pkg::NODE_W-1:0] in_v_node,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             out_merged,
  output logic [ufpc_pkg::NODE_W-1:0]      out_root
);
  import ufpc_pkg::*;

  dp_cmd_t    ctrl_cmd;
  dp_cmd_t    dp_cmd;
  dp_status_t status;

  ufpc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (ctrl_cmd)
  );

  // note_merge is raised only in the link state
  ufpc_link u_link (
    .cmd_in       (ctrl_cmd),
    .link_state   (ctrl_cmd.note_merge),
    .roots_differ (status.roots_differ),
    .cmd_out      (dp_cmd)
  );

  ufpc_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (dp_cmd),
    .status     (status),
    .in_action  (in_action),
    .in_u_node  (in_u_node),
    .in_v_node  (in_v_node),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_merged (out_merged),
    .out_root   (out_root)
  );

endmodule
`default_nettype wire

// ===== hdl/ufpc_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ufpc_checker: port-level checks for the union-find engine
// Watches the handshake ports of the top level over time.
// ----------------------------------------------------------------------------
module ufpc_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_stall,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire logic out_merged,
  input wire logic [ufpc_pkg::NODE_W-1:0] out_root
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_root) && $stable(out_merged))
    else $error("stalled result changed");

  // one transaction at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("accepted a second transaction while busy");

  // reset starts the clearing pass with no result pending
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> in_stall && !out_valid)
    else $error("reset did not stall input or clear result");

  // a new result comes only out of a busy period
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without work in progress");

endmodule

bind union_find_path_compression ufpc_checker u_ufpc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_merged (out_merged),
  .out_root   (out_root)
);
`default_nettype wire

// ===== bench/union_find_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// union_find_checker: result checker for the union-find engine
// Keeps its own copy of the parent table, works out the result of every
// accepted input transaction and compares it with the results in order.
// ----------------------------------------------------------------------------
package ufpc_tb_pkg;

  localparam logic ACT_UNION = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;

  typedef struct packed {
    logic                        merged;
    logic [ufpc_pkg::NODE_W-1:0] root;
  } uf_result_t;

endpackage

module union_find_checker (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  input  wire logic                        in_stall,
  input  wire logic                        in_action,
  input  wire logic [ufpc_pkg::NODE_W-1:0] in_u_node,
  input  wire logic [ufpc_pkg::NODE_W-1:0] in_v_node,
  input  wire logic                        out_valid,
  input  wire logic                        out_stall,
  input  wire logic                        out_merged,
  input  wire logic [ufpc_pkg::NODE_W-1:0] out_root,
  output int                               errors,
  output int                               pending
);
  import ufpc_pkg::*;
  import ufpc_tb_pkg::*;

  localparam int SHOW_LIMIT = 10;

  logic [NODE_W-1:0] parent_mirror [0:NODES-1];
  uf_result_t        union_results_q [$];
  int                fail_count = 0;

  function automatic void clear_mirror();
    for (int i = 0; i < NODES; i++) parent_mirror[i] = NODE_W'(i);
  endfunction

  // Walk up to the root, then point every node on the path straight at it.
  // A walk stops at the last valid node on a link that leaves the table.
  function automatic logic [NODE_W-1:0] find_and_compress(input logic [NODE_W-1:0] start);
    logic [NODE_W-1:0] top_node;
    logic [NODE_W-1:0] nxt;
    logic [NODE_W-1:0] walk;
    int                steps;
    bit                stop;
    top_node = start;
    steps    = 0;
    stop     = 1'b0;
    while (!stop && steps < NODES) begin
      nxt = parent_mirror[top_node];
      if (nxt == top_node || nxt >= NODES) begin
        stop = 1'b1;
      end else begin
        top_node = nxt;
        steps++;
      end
    end
    walk  = start;
    steps = 0;
    stop  = 1'b0;
    while (!stop && walk != top_node && steps < NODES) begin
      nxt                 = parent_mirror[walk];
      parent_mirror[walk] = top_node;
      if (nxt >= NODES) begin
        stop = 1'b1;
      end else begin
        walk = nxt;
        steps++;
      end
    end
    return top_node;
  endfunction

  function automatic uf_result_t predict_union(input logic act, input logic [NODE_W-1:0] u,
                                               input logic [NODE_W-1:0] v);
    uf_result_t        res;
    logic [NODE_W-1:0] ru;
    logic [NODE_W-1:0] rv;
    res = '0;
    if (act == ACT_CLEAR) begin
      clear_mirror();
    end else if (u < NODES && v < NODES) begin
      ru = find_and_compress(u);
      rv = find_and_compress(v);
      if (ru != rv) begin
        parent_mirror[rv] = ru;
        res.merged        = 1'b1;
      end
      res.root = ru;
    end
    return res;
  endfunction

  always @(posedge clk) begin : monitor
    uf_result_t want;
    uf_result_t got;
    if (!rst_n) begin
      clear_mirror();
      union_results_q.delete();
    end else begin
      if (in_valid && !in_stall)
        union_results_q.insert(union_results_q.size(),
                               predict_union(in_action, in_u_node, in_v_node));
      if (out_valid && !out_stall) begin
        got.merged = out_merged;
        got.root   = out_root;
        if (union_results_q.size() == 0) begin
          fail_count++;
          if (fail_count <= SHOW_LIMIT)
            $display("%0t: unexpected result merged=%0d root=%0d", $realtime, got.merged,
                     got.root);
        end else begin
          want = union_results_q.pop_front();
          if (got.merged !== want.merged || got.root !== want.root) begin
            fail_count++;
            if (fail_count <= SHOW_LIMIT)
              $display("%0t: mismatch: expected merged=%0d root=%0d, got merged=%0d root=%0d",
                       $realtime, want.merged, want.root, got.merged, got.root);
          end
        end
      end
    end
    errors  <= fail_count;
    pending <= union_results_q.size();
  end

endmodule

// ===== bench/tb_union_find_path_compression.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_union_find_path_compression: testbench for the union-find engine
// Drives directed and random union and clear transactions with random
// idling on both channels; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_union_find_path_compression;
  import ufpc_pkg::*;
  import ufpc_tb_pkg::*;

  localparam int PERIOD      = 12;
  localparam int ITEMS       = 1800;
  localparam int TAIL_ITEMS  = 150;
  localparam int DRAIN_LIMIT = 20000;
  localparam int RUN_CYCLES  = 10_000_000;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_action = ACT_UNION;
  logic [NODE_W-1:0] in_u_node = '0;
  logic [NODE_W-1:0] in_v_node = '0;
  logic              out_stall = 1'b0;
  wire logic              in_stall;
  wire logic              out_valid;
  wire logic              out_merged;
  wire logic [NODE_W-1:0] out_root;
  int                errors;
  int                pending;

  logic quiet       = 1'b0;
  int   total_sent  = 0;
  int   win_base    = 0;
  int   win_size    = 32;
  int   stall_run   = 0;
  logic stall_on    = 1'b0;

  always #(PERIOD / 2) clk = ~clk;

  union_find_path_compression uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_action (in_action),
    .in_u_node (in_u_node),
    .in_v_node (in_v_node),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_merged(out_merged),
    .out_root  (out_root)
  );

  union_find_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_action (in_action),
    .in_u_node (in_u_node),
    .in_v_node (in_v_node),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_merged(out_merged),
    .out_root  (out_root),
    .errors    (errors),
    .pending   (pending)
  );

  // Receiver back-pressure: bursts of stall between runs of no stall.
  always @(posedge clk) begin
    if (!rst_n || quiet) begin
      stall_run = 0;
      stall_on  = 1'b0;
    end else if (stall_run == 0) begin
      stall_on  = ($urandom_range(0, 2) == 0);
      stall_run = stall_on ? $urandom_range(1, 12) : $urandom_range(1, 24);
    end
    if (stall_run > 0) stall_run--;
    out_stall <= stall_on;
  end

  task automatic send_txn(input logic act, input logic [NODE_W-1:0] u,
                          input logic [NODE_W-1:0] v);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_action <= act;
    in_u_node <= u;
    in_v_node <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    total_sent++;
  endtask

  task automatic drain_wait();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  function automatic logic [NODE_W-1:0] window_node();
    return NODE_W'((win_base + $urandom_range(0, win_size - 1)) % NODES);
  endfunction

  function automatic logic [NODE_W-1:0] any_node();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? '1 : '0;
    return NODE_W'($urandom_range(0, NODES - 1));
  endfunction

  // Link a run of nodes into one long path, then find from its bottom.
  task automatic send_chain();
    int                len;
    int                base;
    int                stride;
    logic [NODE_W-1:0] lower;
    logic [NODE_W-1:0] upper;
    len    = $urandom_range(4, 24);
    base   = $urandom_range(0, NODES - 1);
    stride = 2 * $urandom_range(0, NODES / 2 - 1) + 1;
    for (int k = 0; k < len; k++) begin
      lower = NODE_W'((base + k * stride) % NODES);
      upper = NODE_W'((base + (k + 1) * stride) % NODES);
      send_txn(ACT_UNION, upper, lower);
    end
    send_txn(ACT_UNION, NODE_W'(base % NODES), window_node());
  endtask

  initial begin : stimulus
    int                pick;
    int                waited;
    logic [NODE_W-1:0] u;
    logic [NODE_W-1:0] v;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes, same set, self union, a deep path, clear.
    send_txn(ACT_UNION, '0, '1);
    send_txn(ACT_UNION, '1, '0);
    send_txn(ACT_UNION, NODE_W'(5), NODE_W'(5));
    send_txn(ACT_UNION, '1, NODE_W'(1022));
    for (int k = 100; k < 112; k++) send_txn(ACT_UNION, NODE_W'(k + 1), NODE_W'(k));
    send_txn(ACT_UNION, NODE_W'(100), NODE_W'(1021));
    send_txn(ACT_UNION, NODE_W'(100), NODE_W'(112));
    drain_wait();
    send_txn(ACT_CLEAR, '1, '1);
    send_txn(ACT_UNION, '0, '1);
    send_txn(ACT_UNION, NODE_W'(10'h2AA), NODE_W'(10'h155));

    // Random: mostly unions inside a moving window so sets grow and paths form.
    while (total_sent < ITEMS) begin
      if (total_sent >= ITEMS - TAIL_ITEMS) quiet <= 1'b1;
      if ($urandom_range(0, 49) == 0) begin
        win_base = $urandom_range(0, NODES - 1);
        case ($urandom_range(0, 3))
          0:       win_size = 8;
          1:       win_size = 32;
          2:       win_size = 128;
          default: win_size = NODES;
        endcase
      end
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        send_txn(ACT_CLEAR, any_node(), any_node());
      end else if (pick < 11) begin
        send_chain();
      end else if (pick < 13 && !quiet) begin
        drain_wait();
        send_txn(ACT_UNION, window_node(), window_node());
      end else if (pick < 25) begin
        send_txn(ACT_UNION, any_node(), any_node());
      end else begin
        u = window_node();
        v = ($urandom_range(0, 19) == 0) ? u : window_node();
        send_txn(ACT_UNION, u, v);
      end
    end

    in_valid <= 1'b0;
    waited = 0;
    do begin
      @(negedge clk);
      waited++;
    end while (pending != 0 && waited < DRAIN_LIMIT);
    repeat (64) @(posedge clk);
    @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #(64'd1 * RUN_CYCLES * PERIOD);
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/ufpc_pkg.sv
hdl/ufpc_dpath.sv
hdl/ufpc_ctrl.sv
hdl/ufpc_link.sv
hdl/union_find_path_compression.sv
hdl/ufpc_checker.sv
bench/union_find_checker.sv
bench/tb_union_find_path_compression.sv
